>>> hdl/rsf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsf_pkg: shared constants for the float-key radix sorter
// Field widths, default sizing and the float-to-ascending key mapping.
// ----------------------------------------------------------------------------
package rsf_pkg;

  localparam int KEY_W           = 32;
  localparam int TAG_W           = 32;
  localparam int ENTRY_W         = KEY_W + TAG_W;
  localparam int MAX_ENTRIES_DEF = 64;
  localparam int DIGIT_BITS_DEF  = 8;

  localparam logic [KEY_W-1:0] KEY_SIGN = 32'h8000_0000;

  typedef logic [KEY_W-1:0] key_t;

  // Negative floats invert fully, others get the sign bit set.
  function automatic key_t order_key(input key_t raw);
    key_t res;
    if ((raw & KEY_SIGN) != '0) begin
      res = ~raw;
    end else begin
      res = raw | KEY_SIGN;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

>>> hdl/rsf_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsf_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rsf_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

>>> hdl/radix_sort_float_keys.sv
`default_nettype none
// ----------------------------------------------------------------------------
// radix_sort_float_keys: LSD radix sorter for float-keyed entries
// Loads a batch of key/tag entries, sorts them by float order with a
// stable digit-by-digit radix sort over two stores, then streams them out.
// ----------------------------------------------------------------------------
// Loading: one entry per cycle; in_stall stays low while the batch loads.
// Sort: P = ceil(32/DIGIT_BITS) passes, each of clear, count, prefix and scatter
//   (scatter as read-modify-write on the offset RAM).
// Output: one sorted entry at a time, each held while out_stall is high; the next batch
//   loads after the last entry is taken.
// Reset (rst_n low, synchronous) empties the batch and clears the overflow flag.
module radix_sort_float_keys #(
  parameter int MAX_ENTRIES = rsf_pkg::MAX_ENTRIES_DEF,
  parameter int DIGIT_BITS  = rsf_pkg::DIGIT_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [rsf_pkg::KEY_W-1:0] in_key_bits,
  input  wire logic [rsf_pkg::TAG_W-1:0] in_tag,
  input  wire logic                      in_last_entry,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [rsf_pkg::KEY_W-1:0]      out_sorted_key_bits,
  output logic [rsf_pkg::TAG_W-1:0]      out_sorted_tag,
  output logic                           out_last_result,
  output logic                           out_overflowed
);

  localparam int ENTRY_W     = rsf_pkg::ENTRY_W;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int NUM_BUCKETS = 1 << DIGIT_BITS;
  localparam int NUM_PASSES  = (rsf_pkg::KEY_W + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int PASS_W      = $clog2(NUM_PASSES);
  localparam int SHIFT_W     = $clog2(rsf_pkg::KEY_W);
  localparam logic [PASS_W-1:0] LAST_PASS = PASS_W'(NUM_PASSES - 1);
  localparam logic FINAL_IN_SCRATCH = ((NUM_PASSES % 2) == 1);

  localparam logic [3:0] S_LOAD     = 4'd0;
  localparam logic [3:0] S_CLR      = 4'd1;
  localparam logic [3:0] S_CNT_RD   = 4'd2;
  localparam logic [3:0] S_CNT_OFF  = 4'd3;
  localparam logic [3:0] S_CNT_WR   = 4'd4;
  localparam logic [3:0] S_PFX_RD   = 4'd5;
  localparam logic [3:0] S_PFX_WR   = 4'd6;
  localparam logic [3:0] S_SC_RD    = 4'd7;
  localparam logic [3:0] S_SC_OFF   = 4'd8;
  localparam logic [3:0] S_SC_WR    = 4'd9;
  localparam logic [3:0] S_OUT_RD   = 4'd10;
  localparam logic [3:0] S_OUT_LD   = 4'd11;
  localparam logic [3:0] S_OUT_WAIT = 4'd12;

  // control state
  logic [3:0]            state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [PASS_W-1:0]     pass_r, pass_nxt;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic [DIGIT_BITS-1:0] bkt_r, bkt_nxt;
  logic [CNT_W-1:0]      total_r, total_nxt;
  logic                  oval_r, oval_nxt;

  // payload
  logic [DIGIT_BITS-1:0]     dig_r, dig_nxt;
  logic [ENTRY_W-1:0]        ent_r, ent_nxt;
  logic [rsf_pkg::KEY_W-1:0] okey_r, okey_nxt;
  logic [rsf_pkg::TAG_W-1:0] otag_r, otag_nxt;
  logic                      olast_r, olast_nxt;
  logic                      oovf_r, oovf_nxt;

  // memory ports
  logic                   e_we, e_re, s_we, s_re, o_we, o_re;
  logic [IDX_W-1:0]       e_waddr, e_raddr, s_waddr, s_raddr;
  logic [ENTRY_W-1:0]     e_wdata, s_wdata, e_rdata, s_rdata;
  logic [DIGIT_BITS-1:0]  o_waddr, o_raddr;
  logic [CNT_W-1:0]       o_wdata, o_rdata;

  rsf_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ENTRIES)) u_entry_ram (
    .clk(clk), .wr_en(e_we), .wr_addr(e_waddr), .wr_data(e_wdata),
    .rd_en(e_re), .rd_addr(e_raddr), .rd_data(e_rdata)
  );

  rsf_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ENTRIES)) u_scratch_ram (
    .clk(clk), .wr_en(s_we), .wr_addr(s_waddr), .wr_data(s_wdata),
    .rd_en(s_re), .rd_addr(s_raddr), .rd_data(s_rdata)
  );

  rsf_ram #(.WIDTH(CNT_W), .DEPTH(NUM_BUCKETS)) u_offset_ram (
    .clk(clk), .wr_en(o_we), .wr_addr(o_waddr), .wr_data(o_wdata),
    .rd_en(o_re), .rd_addr(o_raddr), .rd_data(o_rdata)
  );

  logic                      in_acc, out_acc;
  logic                      src_scratch;
  logic [ENTRY_W-1:0]        src_rdata, fin_rdata;
  logic [SHIFT_W-1:0]        shift;
  logic [rsf_pkg::KEY_W-1:0] mapped_sh;
  logic [DIGIT_BITS-1:0]     digit;
  logic [CNT_W-1:0]          last_idx;
  logic                      bkt_end;

  assign in_acc      = in_valid && !in_stall;
  assign out_acc     = oval_r && !out_stall;
  assign src_scratch = pass_r[0];
  assign src_rdata   = src_scratch ? s_rdata : e_rdata;
  assign fin_rdata   = FINAL_IN_SCRATCH ? s_rdata : e_rdata;
  assign shift       = SHIFT_W'(pass_r * DIGIT_BITS);
  // shared shift unit: pick the current digit of the mapped key
  assign mapped_sh   = rsf_pkg::order_key(src_rdata[ENTRY_W-1:rsf_pkg::TAG_W]) >> shift;
  assign digit       = mapped_sh[DIGIT_BITS-1:0];
  assign last_idx    = cnt_r - CNT_W'(1);
  assign bkt_end     = (bkt_r == {DIGIT_BITS{1'b1}});

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    pass_nxt  = pass_r;
    idx_nxt   = idx_r;
    bkt_nxt   = bkt_r;
    total_nxt = total_r;
    oval_nxt  = oval_r;
    dig_nxt   = dig_r;
    ent_nxt   = ent_r;
    okey_nxt  = okey_r;
    otag_nxt  = otag_r;
    olast_nxt = olast_r;
    oovf_nxt  = oovf_r;

    e_we = 1'b0; e_waddr = '0; e_wdata = '0; e_re = 1'b0; e_raddr = '0;
    s_we = 1'b0; s_waddr = '0; s_wdata = '0; s_re = 1'b0; s_raddr = '0;
    o_we = 1'b0; o_waddr = '0; o_wdata = '0; o_re = 1'b0; o_raddr = '0;

    unique case (state_r) inside
      S_LOAD: begin
        if (in_acc) begin
          if (cnt_r < CNT_W'(MAX_ENTRIES)) begin
            e_we    = 1'b1;
            e_waddr = cnt_r[IDX_W-1:0];
            e_wdata = {in_key_bits, in_tag};
            cnt_nxt = cnt_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last_entry) begin
            state_nxt = S_CLR;
            pass_nxt  = '0;
            bkt_nxt   = '0;
          end
        end
      end
      S_CLR: begin
        o_we    = 1'b1;
        o_waddr = bkt_r;
        bkt_nxt = bkt_r + DIGIT_BITS'(1);
        if (bkt_end) begin
          idx_nxt   = '0;
          state_nxt = S_CNT_RD;
        end
      end
      S_CNT_RD, S_SC_RD: begin
        if (src_scratch) begin
          s_re    = 1'b1;
          s_raddr = idx_r[IDX_W-1:0];
        end else begin
          e_re    = 1'b1;
          e_raddr = idx_r[IDX_W-1:0];
        end
        state_nxt = (state_r == S_CNT_RD) ? S_CNT_OFF : S_SC_OFF;
      end
      S_CNT_OFF, S_SC_OFF: begin
        o_re      = 1'b1;
        o_raddr   = digit;
        dig_nxt   = digit;
        ent_nxt   = src_rdata;
        state_nxt = (state_r == S_CNT_OFF) ? S_CNT_WR : S_SC_WR;
      end
      S_CNT_WR: begin
        o_we    = 1'b1;
        o_waddr = dig_r;
        o_wdata = o_rdata + CNT_W'(1);
        idx_nxt = idx_r + CNT_W'(1);
        if (idx_r == last_idx) begin
          bkt_nxt   = '0;
          total_nxt = '0;
          state_nxt = S_PFX_RD;
        end else begin
          state_nxt = S_CNT_RD;
        end
      end
      S_PFX_RD: begin
        o_re      = 1'b1;
        o_raddr   = bkt_r;
        state_nxt = S_PFX_WR;
      end
      S_PFX_WR: begin
        // exclusive prefix: bucket gets the running total before its count
        o_we      = 1'b1;
        o_waddr   = bkt_r;
        o_wdata   = total_r;
        total_nxt = total_r + o_rdata;
        bkt_nxt   = bkt_r + DIGIT_BITS'(1);
        if (bkt_end) begin
          idx_nxt   = '0;
          state_nxt = S_SC_RD;
        end else begin
          state_nxt = S_PFX_RD;
        end
      end
      S_SC_WR: begin
        if (src_scratch) begin
          e_we    = 1'b1;
          e_waddr = o_rdata[IDX_W-1:0];
          e_wdata = ent_r;
        end else begin
          s_we    = 1'b1;
          s_waddr = o_rdata[IDX_W-1:0];
          s_wdata = ent_r;
        end
        o_we    = 1'b1;
        o_waddr = dig_r;
        o_wdata = o_rdata + CNT_W'(1);
        idx_nxt = idx_r + CNT_W'(1);
        if (idx_r != last_idx) begin
          state_nxt = S_SC_RD;
        end else if (pass_r == LAST_PASS) begin
          idx_nxt   = '0;
          state_nxt = S_OUT_RD;
        end else begin
          pass_nxt  = pass_r + PASS_W'(1);
          bkt_nxt   = '0;
          state_nxt = S_CLR;
        end
      end
      S_OUT_RD: begin
        if (FINAL_IN_SCRATCH) begin
          s_re    = 1'b1;
          s_raddr = idx_r[IDX_W-1:0];
        end else begin
          e_re    = 1'b1;
          e_raddr = idx_r[IDX_W-1:0];
        end
        state_nxt = S_OUT_LD;
      end
      S_OUT_LD: begin
        okey_nxt  = fin_rdata[ENTRY_W-1:rsf_pkg::TAG_W];
        otag_nxt  = fin_rdata[rsf_pkg::TAG_W-1:0];
        olast_nxt = (idx_r == last_idx);
        oovf_nxt  = ovf_r;
        oval_nxt  = 1'b1;
        state_nxt = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (out_acc) begin
          oval_nxt = 1'b0;
          idx_nxt  = idx_r + CNT_W'(1);
          if (olast_r) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            state_nxt = S_OUT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      pass_r  <= '0;
      idx_r   <= '0;
      bkt_r   <= '0;
      total_r <= '0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      pass_r  <= pass_nxt;
      idx_r   <= idx_nxt;
      bkt_r   <= bkt_nxt;
      total_r <= total_nxt;
      oval_r  <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dig_r   <= dig_nxt;
    ent_r   <= ent_nxt;
    okey_r  <= okey_nxt;
    otag_r  <= otag_nxt;
    olast_r <= olast_nxt;
    oovf_r  <= oovf_nxt;
  end

  assign in_stall            = (state_r != S_LOAD);
  assign out_valid           = oval_r;
  assign out_sorted_key_bits = okey_r;
  assign out_sorted_tag      = otag_r;
  assign out_last_result     = olast_r;
  assign out_overflowed      = oovf_r;

`ifndef ASSERT_OFF
  a_oval_only_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    oval_r |-> (state_r == S_OUT_WAIT))
    else $error("result beat shown outside the output wait state");

  a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry count beyond capacity");

  a_scatter_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SC_WR) |-> (o_rdata < cnt_r))
    else $error("scatter position past the batch");

  a_batch_close: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && olast_r) |=> ((cnt_r == '0) && !ovf_r && (state_r == S_LOAD)))
    else $error("batch state not cleared after final beat");
`endif

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for radix_sort_float_keys
// Loads batches of float-keyed entries with bursty valid and a patterned
// out_stall, predicts the sorted stream with a stable float-order sort and
// compares every result beat field by field, including the overflow case.
// ----------------------------------------------------------------------------
module testbench;

  localparam int DEPTH     = rsf_pkg::MAX_ENTRIES_DEF;
  localparam int MAX_CYCLE = 2_000_000;
  localparam int RAND_ITEMS = 230;

  typedef struct {
    logic [rsf_pkg::KEY_W-1:0] key;
    logic [rsf_pkg::TAG_W-1:0] tag;
    logic                      is_last;
    logic                      wait_drain;
  } load_beat_t;

  typedef struct {
    logic [rsf_pkg::KEY_W-1:0] key;
    logic [rsf_pkg::TAG_W-1:0] tag;
    logic                      is_last;
    logic                      ovf;
  } sorted_entry_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [rsf_pkg::KEY_W-1:0] in_key_bits = '0;
  logic [rsf_pkg::TAG_W-1:0] in_tag = '0;
  logic                      in_last_entry = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [rsf_pkg::KEY_W-1:0] out_sorted_key_bits;
  logic [rsf_pkg::TAG_W-1:0] out_sorted_tag;
  logic                      out_last_result;
  logic                      out_overflowed;

  load_beat_t    load_q[$];
  sorted_entry_t sorted_q[$];

  // entries of the batch being loaded, as the block holds them
  logic [31:0] batch_keys[$];
  logic [31:0] batch_tags[$];
  bit          batch_dropped = 1'b0;

  int total_items = 0;
  int accepted_count = 0;
  int errors = 0;
  int cycle_count = 0;

  int gap_left = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int mode_left = 0;
  logic [3:0] stall_phase = '0;

  radix_sort_float_keys #(
    .MAX_ENTRIES (DEPTH),
    .DIGIT_BITS  (rsf_pkg::DIGIT_BITS_DEF)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_key_bits         (in_key_bits),
    .in_tag              (in_tag),
    .in_last_entry       (in_last_entry),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_sorted_key_bits (out_sorted_key_bits),
    .out_sorted_tag      (out_sorted_tag),
    .out_last_result     (out_last_result),
    .out_overflowed      (out_overflowed)
  );

  always #5 clk = ~clk;

  // Unsigned value that ascends with float order.
  function automatic logic [31:0] float_rank(input logic [31:0] raw);
    logic [31:0] r;
    if (raw[31]) begin
      r = ~raw;
    end else begin
      r = {1'b1, raw[30:0]};
    end
    return r;
  endfunction

  // Stable sort of the loaded batch; queue one result beat per stored entry.
  task automatic sort_batch();
    logic [31:0] k[$];
    logic [31:0] t[$];
    logic [31:0] tmp;
    sorted_entry_t res;
    int j;
    k = batch_keys;
    t = batch_tags;
    for (int i = 1; i < k.size(); i++) begin
      j = i;
      // strict compare keeps arrival order for equal ranks
      while (j > 0 && float_rank(k[j-1]) > float_rank(k[j])) begin
        tmp = k[j]; k[j] = k[j-1]; k[j-1] = tmp;
        tmp = t[j]; t[j] = t[j-1]; t[j-1] = tmp;
        j--;
      end
    end
    for (int i = 0; i < k.size(); i++) begin
      res.key = k[i];
      res.tag = t[i];
      res.is_last = (i == k.size() - 1);
      res.ovf = batch_dropped;
      sorted_q.push_back(res);
    end
    batch_keys.delete();
    batch_tags.delete();
    batch_dropped = 1'b0;
  endtask

  task automatic load_entry(input logic [31:0] key, input logic [31:0] tag,
                            input logic last);
    if (batch_keys.size() < DEPTH) begin
      batch_keys.push_back(key);
      batch_tags.push_back(tag);
    end else begin
      batch_dropped = 1'b1;
    end
    if (last) begin
      sort_batch();
    end
  endtask

  task automatic push_beat(input logic [31:0] key, input logic [31:0] tag,
                           input logic last, input logic hold);
    load_beat_t b;
    b.key = key;
    b.tag = tag;
    b.is_last = last;
    b.wait_drain = hold;
    load_q.push_back(b);
    total_items++;
  endtask

  function automatic logic [31:0] special_key(input int sel);
    logic [31:0] k;
    case (sel)
      0:       k = 32'h0000_0000;  // +0
      1:       k = 32'h8000_0000;  // -0
      2:       k = 32'h7F80_0000;  // +inf
      3:       k = 32'hFF80_0000;  // -inf
      4:       k = 32'h7FC0_0000;  // quiet NaN
      5:       k = 32'hFFC0_0000;  // negative NaN
      6:       k = 32'h3F80_0000;  // 1.0
      default: k = 32'hBF80_0000;  // -1.0
    endcase
    return k;
  endfunction

  // Batch of n entries; key style varies so digit passes see ties and spread.
  task automatic queue_batch(input int n, input logic hold);
    int style;
    int pos;
    logic [31:0] base;
    logic [31:0] key;
    logic [31:0] tag;
    style = $urandom_range(0, 2);
    base = $urandom;
    for (int i = 0; i < n; i++) begin
      case (style)
        0: key = $urandom;
        1: key = ($urandom_range(0, 3) == 0) ? base : special_key($urandom_range(0, 7));
        default: begin
          key = base;
          pos = $urandom_range(0, 3);
          key[pos*8 +: 8] = 8'($urandom_range(0, 255));
        end
      endcase
      case ($urandom_range(0, 9))
        0:       tag = 32'h0000_0000;
        1:       tag = 32'hFFFF_FFFF;
        default: tag = $urandom;
      endcase
      push_beat(key, tag, (i == n - 1), hold && (i == 0));
    end
  endtask

  // Driver: bursts of beats with random gaps; predict at each accepted beat.
  always @(posedge clk) begin : drive_proc
    load_beat_t beat;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
      burst_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        load_entry(in_key_bits, in_tag, in_last_entry);
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (load_q.size() != 0 &&
                     !(load_q[0].wait_drain && sorted_q.size() != 0)) begin
          beat = load_q.pop_front();
          in_key_bits <= beat.key;
          in_tag <= beat.tag;
          in_last_entry <= beat.is_last;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: switch among open, random and duty-cycle patterns.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      mode_left <= 0;
    end else begin
      stall_phase <= stall_phase + 1'b1;
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(20, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= 1'($urandom_range(0, 1));
        default: out_stall <= (stall_phase < 4'd10);
      endcase
    end
  end

  // Monitor: check each accepted result beat against the oldest expectation.
  always @(posedge clk) begin : check_proc
    sorted_entry_t exp_e;
    if (rst_n && out_valid && !out_stall) begin
      if (sorted_q.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected result beat: key=%h tag=%h last=%b ovf=%b",
                   out_sorted_key_bits, out_sorted_tag, out_last_result, out_overflowed);
        end
      end else begin
        exp_e = sorted_q.pop_front();
        if (out_sorted_key_bits !== exp_e.key || out_sorted_tag !== exp_e.tag ||
            out_last_result !== exp_e.is_last || out_overflowed !== exp_e.ovf) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: expected key=%h tag=%h last=%b ovf=%b",
                     exp_e.key, exp_e.tag, exp_e.is_last, exp_e.ovf);
            $display("          actual   key=%h tag=%h last=%b ovf=%b",
                     out_sorted_key_bits, out_sorted_tag, out_last_result, out_overflowed);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == MAX_CYCLE) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int n;
    int r;
    // single entry with extreme tag
    push_beat(32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0);
    // signed zeros, infinities, NaNs and denormals in one batch
    push_beat(32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0);
    push_beat(32'h0000_0000, 32'h0000_0001, 1'b0, 1'b0);
    push_beat(32'h7F80_0000, 32'h0000_0002, 1'b0, 1'b0);
    push_beat(32'hFF80_0000, 32'h0000_0003, 1'b0, 1'b0);
    push_beat(32'h7FC0_0000, 32'h0000_0004, 1'b0, 1'b0);
    push_beat(32'hFFC0_0000, 32'h0000_0005, 1'b0, 1'b0);
    push_beat(32'hFFFF_FFFF, 32'h0000_0006, 1'b0, 1'b0);
    push_beat(32'h7FFF_FFFF, 32'h0000_0007, 1'b0, 1'b0);
    push_beat(32'h3F80_0000, 32'h0000_0008, 1'b0, 1'b0);
    push_beat(32'hBF80_0000, 32'h0000_0009, 1'b0, 1'b0);
    push_beat(32'h0000_0001, 32'h0000_000A, 1'b0, 1'b0);
    push_beat(32'h8000_0001, 32'hFFFF_FFFF, 1'b1, 1'b0);
    // equal keys must keep arrival order; hold until the previous batch drains
    push_beat(32'h4049_0FDB, 32'h0000_0010, 1'b0, 1'b1);
    push_beat(32'hC049_0FDB, 32'h0000_0011, 1'b0, 1'b0);
    push_beat(32'h4049_0FDB, 32'h0000_0012, 1'b0, 1'b0);
    push_beat(32'h4049_0FDB, 32'h0000_0013, 1'b0, 1'b0);
    push_beat(32'hC049_0FDB, 32'h0000_0014, 1'b0, 1'b0);
    push_beat(32'h4049_0FDB, 32'h0000_0015, 1'b1, 1'b0);

    // overflow: one batch whose final entry is dropped, one dropping several
    queue_batch(DEPTH + 1, 1'b0);
    queue_batch(DEPTH + 3, 1'b1);
    while (total_items < RAND_ITEMS) begin
      r = $urandom_range(0, 19);
      if (r < 15) begin
        n = $urandom_range(1, 12);
      end else if (r < 19) begin
        n = $urandom_range(13, 40);
      end else begin
        n = DEPTH;
      end
      if (n > RAND_ITEMS - total_items) begin
        n = RAND_ITEMS - total_items;
      end
      queue_batch(n, ($urandom_range(0, 5) == 0));
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_count < total_items) @(posedge clk);
    while (sorted_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (errors == 0 && sorted_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
